FILE: hw/rtl/chte_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash table engine package
// Shared types, codes and default sizes for the chained hash table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package chte_pkg;

  // Default sizes of the table.
  localparam int MAX_BUCKETS_DEF = 64;
  localparam int POOL_NODES_DEF  = 256;
  localparam int DEFAULT_BUCKETS = 16;

  // Operation codes.
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [8:0]  entry_count;
  } rsp_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HEAD,
    S_READ,
    S_CMP,
    S_LINK,
    S_DECIDE,
    S_UPD1,
    S_UPD2,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic clear_all;
    logic load;
    logic mod_step;
    logic head_rd;
    logic node_rd;
    logic advance;
    logic upd1;
    logic upd2;
    logic respond;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic mod_done;
    logic cur_nil;
    logic stop;
  } sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/chte_ctrl.sv
// ----------------------------------------------------------------------------
// Chained hash table engine controller
// Sequences the clearing pass, bucket reduction, chain walk and update.
// ----------------------------------------------------------------------------
`default_nettype none

module chte_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          cfg_valid,
  input  wire chte_pkg::sts_t sts,
  output chte_pkg::ctl_t     ctl,
  output logic               busy,
  output logic               cfg_ready
);
  import chte_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    cfg_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        ctl.clear_step = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        // A pending configuration write takes the idle slot, so commands wait.
        busy      = cfg_valid;
        cfg_ready = 1'b1;
        if (cfg_valid) begin
          ctl.clear_all = 1'b1;
          state_next    = S_CLEAR;
        end else if (start) begin
          ctl.load   = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.mod_done) state_next = S_HEAD;
        else ctl.mod_step = 1'b1;
      end
      S_HEAD: begin
        ctl.head_rd = 1'b1;
        state_next  = S_READ;
      end
      S_READ: begin
        if (sts.cur_nil) state_next = S_DECIDE;
        else begin
          ctl.node_rd = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.stop) state_next = S_DECIDE;
        else state_next = S_LINK;
      end
      S_LINK: begin
        ctl.advance = 1'b1;
        state_next  = S_READ;
      end
      S_DECIDE: begin
        ctl.upd1   = 1'b1;
        state_next = S_UPD2;
      end
      S_UPD2: begin
        ctl.upd2   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        ctl.respond = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/chte_datapath.sv
// ----------------------------------------------------------------------------
// Chained hash table engine datapath
// Holds the bucket and node memories, the reduction and the walk registers.
// ----------------------------------------------------------------------------
`default_nettype none

module chte_datapath #(
  parameter int MAX_BUCKETS = chte_pkg::MAX_BUCKETS_DEF,
  parameter int POOL_NODES  = chte_pkg::POOL_NODES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire chte_pkg::ctl_t ctl,
  input  wire chte_pkg::cmd_t cmd,
  input  wire logic [6:0]     cfg_data,
  output chte_pkg::sts_t      sts,
  output logic                result_valid,
  output chte_pkg::rsp_t      result
);
  import chte_pkg::*;

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = $clog2(POOL_NODES + 1);
  localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int CW = (MAX_BUCKETS > POOL_NODES) ? BW : AW;
  localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

  // Memories.
  logic [NW-1:0] head_mem [MAX_BUCKETS];
  logic [31:0]   key_mem  [POOL_NODES];
  logic [31:0]   pay_mem  [POOL_NODES];
  logic [NW-1:0] link_mem [POOL_NODES];

  logic [6:0]    bcount;
  logic [CW:0]   clr_idx;
  logic [1:0]    op;
  logic [31:0]   key, val;
  logic [32:0]   rem;          // remainder being reduced
  logic [38:0]   divsh;        // shifted divisor
  logic [5:0]    mod_cnt;
  logic [BW-1:0] bkt;
  logic [NW-1:0] cur, prev, free_head, free_link;
  logic [31:0]   rd_key, rd_pay;
  logic [NW-1:0] rd_link;
  logic [8:0]    total;
  logic [1:0]    status;
  logic [31:0]   fval;
  logic          rd_hit, rd_key_gt;
  logic [6:0]    buckets;

  assign buckets = (bcount == 7'd0) ?
    ((DEFAULT_BUCKETS > MAX_BUCKETS) ? 7'(MAX_BUCKETS) : 7'(DEFAULT_BUCKETS)) :
    ((32'(bcount) > MAX_BUCKETS) ? 7'(MAX_BUCKETS) : bcount);

  assign rd_hit    = (rd_key == key);
  assign rd_key_gt = (rd_key > key);

  assign sts.clear_last = (clr_idx == (CW+1)'(((MAX_BUCKETS > POOL_NODES) ?
                                              MAX_BUCKETS : POOL_NODES) - 1));
  assign sts.mod_done   = (mod_cnt == 6'd0);
  assign sts.cur_nil    = (cur == NIL);
  assign sts.stop       = rd_hit || rd_key_gt;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) bcount <= 7'(DEFAULT_BUCKETS);
    else if (ctl.clear_all) bcount <= cfg_data;
  end

  // Clearing pass index.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_all) clr_idx <= '0;
    else if (ctl.clear_step)  clr_idx <= clr_idx + 1'b1;
  end

  // Restoring reduction of the key by the bucket count, one bit a cycle.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op      <= cmd.opcode;
      key     <= cmd.key;
      val     <= cmd.value;
      rem     <= {1'b0, cmd.key};
      divsh   <= {buckets, 32'd0} >> 1;
      mod_cnt <= 6'd32;
    end else if (ctl.mod_step) begin
      if (39'(rem) >= divsh) rem <= 33'(39'(rem) - divsh);
      divsh   <= divsh >> 1;
      mod_cnt <= mod_cnt - 6'd1;
    end
  end

  assign bkt = BW'(rem);

  // Memory reads: the node under the walk and the node after the free head.
  always_ff @(posedge clk) begin
    if (ctl.node_rd) begin
      rd_key  <= key_mem[AW'(cur)];
      rd_pay  <= pay_mem[AW'(cur)];
      rd_link <= link_mem[AW'(cur)];
    end
    free_link <= link_mem[AW'(free_head)];
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    if (ctl.head_rd) begin
      cur  <= head_mem[bkt];
      prev <= NIL;
    end else if (ctl.advance) begin
      prev <= cur;
      cur  <= rd_link;
    end
  end

  // Update and node memory writes.
  always_ff @(posedge clk) begin
    if (ctl.clear_step) begin
      if (clr_idx < (CW+1)'(MAX_BUCKETS)) head_mem[BW'(clr_idx)] <= NIL;
      if (clr_idx < (CW+1)'(POOL_NODES))
        link_mem[AW'(clr_idx)] <= NW'(clr_idx) + 1'b1;
    end
    if (ctl.upd1) begin
      status <= ST_ABSENT;
      fval   <= '0;
      case (op)
        OP_LOOKUP: if (!sts.cur_nil && rd_hit) begin
          status <= ST_OK;
          fval   <= rd_pay;
        end
        OP_INSERT: if (!sts.cur_nil && rd_hit) status <= ST_ABSENT;
          else if (free_head == NIL) status <= ST_FULL;
          else begin
            status <= ST_OK;
            key_mem[AW'(free_head)]  <= key;
            pay_mem[AW'(free_head)]  <= val;
            link_mem[AW'(free_head)] <= cur;
            if (prev == NIL) head_mem[bkt] <= free_head;
            else link_mem[AW'(prev)] <= free_head;
          end
        OP_REMOVE: if (!sts.cur_nil && rd_hit) begin
          status <= ST_OK;
          if (prev == NIL) head_mem[bkt] <= rd_link;
          else link_mem[AW'(prev)] <= rd_link;
          link_mem[AW'(cur)] <= free_head;
        end
        default: ;
      endcase
    end
  end

  // Free list head, entry count and result.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_all) begin
      free_head <= '0;
      total     <= '0;
    end else if (ctl.upd2 && status == ST_OK) begin
      if (op == OP_INSERT) begin
        free_head <= free_link;
        total     <= total + 9'd1;
      end else if (op == OP_REMOVE) begin
        free_head <= cur;
        total     <= total - 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= ctl.respond;
  end

  assign result.status      = status;
  assign result.found_value = fval;
  assign result.entry_count = total;

endmodule

`default_nettype wire

FILE: hw/rtl/chained_hash_table_engine_unit.sv
// ----------------------------------------------------------------------------
// Chained hash table engine
// Sorted separate-chaining table with a node pool and a free list.
// ----------------------------------------------------------------------------
// Usage: drive cmd and raise start; the command transfers at an edge where
// start is high and busy is low. busy is also high while cfg_valid is high
// in the idle state, since a configuration write wins the idle slot.
// One result appears on result for one cycle with result_valid high; the
// receiver cannot stall it.
// From the accepting edge to the edge that takes the result, a command runs
// through the bit-serial reduction of the key by the bucket count and one
// bucket head read, then a read, a compare and a link step for each node
// stepped past. The walk ends when it runs off the end of the chain or
// stops on a node with an equal or larger key; the update states S_DECIDE
// and S_UPD2 and the response follow.
// busy drops in the result cycle, so the next command may transfer at the
// edge that takes the result. One command at a time.
// Configuration: cfg_data transfers when cfg_valid and cfg_ready are high;
// cfg_ready is high only while idle. A write empties the table.
// Reset and every configuration write run a clearing pass through the bucket
// heads and node links, max(MAX_BUCKETS, POOL_NODES) entries (256 by default);
// busy stays high meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_table_engine_unit #(
  parameter int MAX_BUCKETS = chte_pkg::MAX_BUCKETS_DEF,
  parameter int POOL_NODES  = chte_pkg::POOL_NODES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire chte_pkg::cmd_t cmd,
  output logic                result_valid,
  output chte_pkg::rsp_t      result,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [6:0]     cfg_data
);
  import chte_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // Controller.
  chte_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cfg_valid(cfg_valid),
    .sts(sts), .ctl(ctl), .busy(busy), .cfg_ready(cfg_ready)
  );

  // Datapath.
  chte_datapath #(.MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .cmd(cmd), .cfg_data(cfg_data),
    .sts(sts), .result_valid(result_valid), .result(result)
  );

endmodule

`default_nettype wire
